>>> design/best_pkg.sv
// ----------------------------------------------------------------------------
// best_pkg - shared types and constants for the button edge state tracker
// Flag bit positions, command and action codes, and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package best_pkg;

  // Flag bits of one store entry
  localparam logic [3:0] FLAG_PRESSED       = 4'h1;
  localparam logic [3:0] FLAG_JUST_PRESSED  = 4'h2;
  localparam logic [3:0] FLAG_JUST_RELEASED = 4'h4;
  localparam logic [3:0] FLAG_REPEATING     = 4'h8;

  typedef enum logic [1:0] {
    CMD_EVENT      = 2'd0,
    CMD_FOCUS_LOST = 2'd1,
    CMD_PUBLISH    = 2'd2,
    CMD_QUERY      = 2'd3
  } best_op_t;

  typedef enum logic [1:0] {
    ACT_RELEASE = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_REPEAT  = 2'd2
  } best_act_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch the incoming word
    logic clr;       // write zero to both stores at the sweep pointer
    logic sweep_rd;  // read at the sweep pointer, write back in the cycle after
    logic ev_wr;     // write back the event update
    logic strobe;    // result word on the output ports
  } best_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;  // sweep pointer at the last entry
  } best_sts_t;

  // Apply one button event to an entry; unknown action codes leave it as is
  function automatic logic [3:0] flag_update(input logic [3:0] f, input logic [1:0] act);
    logic [3:0] r;
    r = f;
    case (act)
      ACT_PRESS: begin
        if ((f & FLAG_PRESSED) == 4'h0) r = r | FLAG_JUST_PRESSED;
        r = r | FLAG_PRESSED;
      end
      ACT_RELEASE: begin
        r = (r & ~(FLAG_PRESSED | FLAG_REPEATING)) | FLAG_JUST_RELEASED;
      end
      ACT_REPEAT: begin
        r = r | FLAG_REPEATING;
      end
      default: begin
        r = f;
      end
    endcase
    return r;
  endfunction

  // Release a held entry on focus loss
  function automatic logic [3:0] flag_release(input logic [3:0] f);
    logic [3:0] r;
    r = f;
    if ((f & FLAG_PRESSED) != 4'h0) begin
      r = (f & ~(FLAG_PRESSED | FLAG_REPEATING)) | FLAG_JUST_RELEASED;
    end
    return r;
  endfunction

endpackage

>>> design/best_ctrl.sv
// ----------------------------------------------------------------------------
// best_ctrl - sequencing controller
// Runs the clearing pass after reset, accepts words, and steps the datapath
// through single-entry accesses and whole-store sweeps.
// ----------------------------------------------------------------------------
module best_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_command,
  input  best_pkg::best_sts_t   sts,
  output best_pkg::best_cmd_t   cmd,
  output logic                  busy
);
  import best_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ONE   = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DRAIN = 5'b10000
  } best_state_t;

  best_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_FOCUS_LOST || in_command == CMD_PUBLISH) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_ONE;
          end
        end
      end
      S_ONE: begin
        cmd.ev_wr  = 1'b1;
        cmd.strobe = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (sts.cnt_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last write-back of the sweep happens here
        cmd.strobe = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/best_dpath.sv
// ----------------------------------------------------------------------------
// best_dpath - flag stores and update logic
// Pending and current stores hold keys then buttons in one address space.
// Reads are registered; sweeps write back in the cycle after the read.
// ----------------------------------------------------------------------------
module best_dpath #(
  parameter int KEY_COUNT    = 512,
  parameter int BUTTON_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  best_pkg::best_cmd_t   cmd,
  output best_pkg::best_sts_t   sts,
  input  logic [1:0]            in_command,
  input  logic                  in_device,
  input  logic signed [10:0]    in_index,
  input  logic [1:0]            in_action,
  output logic                  out_pressed,
  output logic                  out_just_pressed,
  output logic                  out_just_released,
  output logic                  out_repeating
);
  import best_pkg::*;

  localparam int TOTAL = KEY_COUNT + BUTTON_COUNT;
  localparam int AW    = $clog2(TOTAL);

  logic [3:0] pend_mem [TOTAL];
  logic [3:0] cur_mem  [TOTAL];

  logic [1:0]    op_r;
  logic [1:0]    action_r;
  logic          valid_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          sweep_wr_r;
  logic [AW-1:0] sweep_addr_r;
  logic [3:0]    pend_rd_r, cur_rd_r;

  logic [9:0]    idx10;
  logic          in_valid;
  logic [AW-1:0] in_addr, rd_addr;
  logic          pend_we, cur_we;
  logic [AW-1:0] pend_wa, cur_wa;
  logic [3:0]    pend_wd, cur_wd;
  logic [3:0]    flags;

  // Decode the incoming index
  assign idx10 = in_index[9:0];
  always_comb begin
    if (in_index[10]) begin
      in_valid = 1'b0;
    end else if (in_device) begin
      in_valid = ({1'b0, idx10} < 11'(BUTTON_COUNT));
    end else begin
      in_valid = ({1'b0, idx10} < 11'(KEY_COUNT));
    end
  end

  always_comb begin
    if (!in_valid) begin
      in_addr = '0;
    end else if (in_device) begin
      in_addr = AW'(KEY_COUNT) + AW'(idx10);
    end else begin
      in_addr = AW'(idx10);
    end
  end

  assign rd_addr = cmd.sweep_rd ? cnt_r : in_addr;

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_command;
      action_r <= in_action;
      valid_r  <= in_valid;
      addr_r   <= in_addr;
    end
  end

  // Sweep pointer, wraps after the last entry
  assign sts.cnt_last = (cnt_r == AW'(TOTAL - 1));
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr || cmd.sweep_rd) begin
      cnt_nxt = sts.cnt_last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sweep_wr_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      sweep_wr_r <= cmd.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    sweep_addr_r <= cnt_r;
  end

  // Write ports
  always_comb begin
    pend_we = 1'b0;
    pend_wa = addr_r;
    pend_wd = pend_rd_r;
    cur_we  = 1'b0;
    cur_wa  = sweep_addr_r;
    cur_wd  = pend_rd_r;
    if (cmd.clr) begin
      pend_we = 1'b1;
      pend_wa = cnt_r;
      pend_wd = '0;
      cur_we  = 1'b1;
      cur_wa  = cnt_r;
      cur_wd  = '0;
    end else if (sweep_wr_r) begin
      pend_we = 1'b1;
      pend_wa = sweep_addr_r;
      if (op_r == CMD_FOCUS_LOST) begin
        pend_wd = flag_release(pend_rd_r);
      end else begin
        pend_wd = pend_rd_r & (FLAG_PRESSED | FLAG_REPEATING);
        cur_we  = 1'b1;
      end
    end else if (cmd.ev_wr && valid_r && op_r == CMD_EVENT) begin
      pend_we = 1'b1;
      pend_wd = flag_update(pend_rd_r, action_r);
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd_r <= pend_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd_r <= cur_mem[rd_addr];
  end

  // Result word: only a valid query reports flags
  assign flags = (valid_r && op_r == CMD_QUERY) ? cur_rd_r : 4'h0;

  assign out_pressed       = (flags & FLAG_PRESSED)       != 4'h0;
  assign out_just_pressed  = (flags & FLAG_JUST_PRESSED)  != 4'h0;
  assign out_just_released = (flags & FLAG_JUST_RELEASED) != 4'h0;
  assign out_repeating     = (flags & FLAG_REPEATING)     != 4'h0;

endmodule

>>> design/button_edge_state_tracker.sv
// ----------------------------------------------------------------------------
// button_edge_state_tracker - key and mouse button edge flag tracker
// Keeps pressed / just pressed / just released / repeating per key and per
// button in a pending store, publishes it to a current store at frame start.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | fields
//  ---------+----------------------+---------------------------------------
//  input    | start, busy          | in_command, in_device, in_index, in_action
//  result   | out_strobe           | out_pressed, out_just_pressed,
//           |                      | out_just_released, out_repeating
//
// Timing: a button event or a query is accepted, then the registered store
// read is updated or reported. Focus lost and frame start walk the stores
// one entry per cycle over the single write port of each store.
// Reset: a clearing pass zeroes both stores, one entry per cycle, and busy
// stays high meanwhile.
// Every accepted word gives exactly one result word, strobed for one cycle;
// the receiver cannot stall, so the result is never held.
// ----------------------------------------------------------------------------
module button_edge_state_tracker #(
  parameter int KEY_COUNT    = 512,
  parameter int BUTTON_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic               in_device,
  input  logic signed [10:0] in_index,
  input  logic [1:0]         in_action,
  output logic               out_strobe,
  output logic               out_pressed,
  output logic               out_just_pressed,
  output logic               out_just_released,
  output logic               out_repeating
);
  import best_pkg::*;

  best_cmd_t cmd;
  best_sts_t sts;

  // Controller: clearing pass, accept, single access or sweep, strobe
  best_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Datapath: both stores, sweep pointer and flag update logic
  best_dpath #(
    .KEY_COUNT    (KEY_COUNT),
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_device         (in_device),
    .in_index          (in_index),
    .in_action         (in_action),
    .out_pressed       (out_pressed),
    .out_just_pressed  (out_just_pressed),
    .out_just_released (out_just_released),
    .out_repeating     (out_repeating)
  );

  assign out_strobe = cmd.strobe;

  // A result only ever appears while a word is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // An accepted word blocks the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // One result per word: strobes never come back to back
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("double result strobe");

  // The clearing pass never overlaps a result or a sweep read
  a_no_clr_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !out_strobe && !cmd.sweep_rd)
    else $error("clearing pass overlaps other work");

endmodule
